// ----- hdl/wrdb_pkg.sv -----
package wrdb_pkg;

  localparam int unsigned SampleBits  = 16;
  localparam int unsigned WinBits     = 17;
  localparam int unsigned CfgBits     = 24;
  localparam int unsigned EnergyBits  = 47;
  localparam int unsigned DivBits     = 48;
  localparam int unsigned DividendLen = EnergyBits + 48;
  localparam int unsigned QuotBits    = 63;
  localparam int unsigned XBits       = 57;
  localparam int unsigned CntBits     = 7;

  localparam logic [WinBits-1:0]    WinMax     = 17'd65536;
  localparam logic [EnergyBits-1:0] EnergyMax  = {EnergyBits{1'b1}};
  localparam logic [30:0]           FullScale  = 31'h7FFF_FFFF;
  localparam logic [63:0]           QSat       = 64'h4000_0000_0000_0000;
  localparam logic [29:0]           Log10Two   = 30'd323228497;

  localparam logic [CntBits-1:0] DivSteps  = 7'd94;
  localparam logic [CntBits-1:0] SqrtSteps = 7'd31;
  localparam logic [CntBits-1:0] LogSteps  = 7'd23;

  typedef enum logic [1:0] {
    RegWindow   = 2'd0,
    RegGain     = 2'd1,
    RegPostGain = 2'd2,
    RegOffset   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic acc;
    logic prep;
    logic div;
    logic sqi;
    logic sqrt;
    logic mulx;
    logic norm;
    logic err;
    logic logi;
    logic logs;
    logic gmul;
    logic tmul;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic fire;
    logic x_zero;
    logic x_norm;
  } sts_t;

endpackage

// ----- hdl/windowed_rms_db_meter.sv -----
// Samples are taken one per cycle while a window fills.
// The last sample of a window starts the back end: a 95-step restoring divider,
// a 32-step square root, 1 to 56 normalizing shifts and 24 log squarings. The
// result becomes valid when the back end is done (a zero log argument skips the log steps);
// input stays stalled until then, and longer while an older result is still waiting.
// Reset (asynchronous, active low) clears sum, count and result valid; loads defaults.
module windowed_rms_db_meter (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [1:0]                             cfg_idx_i,
  input  logic [wrdb_pkg::CfgBits-1:0]           cfg_data_i,
  input  logic                                   sample_valid_i,
  output logic                                   sample_stall_o,
  input  logic signed [wrdb_pkg::SampleBits-1:0] sample_i,
  output logic                                   result_valid_o,
  input  logic                                   result_stall_i,
  output logic signed [15:0]                     level_db_o,
  output logic                                   log_domain_error_o
);
  import wrdb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  wrdb_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_valid_i (sample_valid_i),
    .sample_stall_o (sample_stall_o),
    .result_valid_o (result_valid_o),
    .result_stall_i (result_stall_i),
    .sts_i          (sts),
    .cmd_o          (cmd)
  );

  wrdb_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .sample_i           (sample_i),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .level_db_o         (level_db_o),
    .log_domain_error_o (log_domain_error_o)
  );

endmodule

// ----- hdl/wrdb_ctrl.sv -----
module wrdb_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            sample_valid_i,
  output logic            sample_stall_o,
  output logic            result_valid_o,
  input  logic            result_stall_i,
  input  wrdb_pkg::sts_t  sts_i,
  output wrdb_pkg::cmd_t  cmd_o
);
  import wrdb_pkg::*;

  typedef enum logic [11:0] {
    StIdle = 12'b0000_0000_0001,
    StPrep = 12'b0000_0000_0010,
    StDiv  = 12'b0000_0000_0100,
    StSqi  = 12'b0000_0000_1000,
    StSqrt = 12'b0000_0001_0000,
    StMulx = 12'b0000_0010_0000,
    StNorm = 12'b0000_0100_0000,
    StLogi = 12'b0000_1000_0000,
    StLog  = 12'b0001_0000_0000,
    StGmul = 12'b0010_0000_0000,
    StTmul = 12'b0100_0000_0000,
    StFin  = 12'b1000_0000_0000
  } state_e;

  state_e             state_q, state_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               valid_q, valid_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    valid_d = valid_q && result_stall_i;
    unique case (state_q)
      StIdle: begin
        if (sample_valid_i) begin
          cmd_o.acc = 1'b1;
          if (sts_i.fire) state_d = StPrep;
        end
      end
      StPrep: begin
        cmd_o.prep = 1'b1;
        cnt_d      = DivSteps;
        state_d    = StDiv;
      end
      StDiv: begin
        cmd_o.div = 1'b1;
        cnt_d     = cnt_q - 1'b1;
        if (cnt_q == '0) state_d = StSqi;
      end
      StSqi: begin
        cmd_o.sqi = 1'b1;
        cnt_d     = SqrtSteps;
        state_d   = StSqrt;
      end
      StSqrt: begin
        cmd_o.sqrt = 1'b1;
        cnt_d      = cnt_q - 1'b1;
        if (cnt_q == '0) state_d = StMulx;
      end
      StMulx: begin
        cmd_o.mulx = 1'b1;
        state_d    = StNorm;
      end
      StNorm: begin
        if (sts_i.x_zero) begin
          cmd_o.err = 1'b1;
          state_d   = StFin;
        end else if (sts_i.x_norm) begin
          state_d = StLogi;
        end else begin
          cmd_o.norm = 1'b1;
        end
      end
      StLogi: begin
        cmd_o.logi = 1'b1;
        cnt_d      = LogSteps;
        state_d    = StLog;
      end
      StLog: begin
        cmd_o.logs = 1'b1;
        cnt_d      = cnt_q - 1'b1;
        if (cnt_q == '0) state_d = StGmul;
      end
      StGmul: begin
        cmd_o.gmul = 1'b1;
        state_d    = StTmul;
      end
      StTmul: begin
        cmd_o.tmul = 1'b1;
        state_d    = StFin;
      end
      StFin: begin
        // The result register frees up in the same cycle its transaction completes.
        if (!valid_q || !result_stall_i) begin
          cmd_o.load = 1'b1;
          valid_d    = 1'b1;
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  assign sample_stall_o = (state_q != StIdle);
  assign result_valid_o = valid_q;

endmodule

// ----- hdl/wrdb_dp.sv -----
module wrdb_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_idx_i,
  input  logic [wrdb_pkg::CfgBits-1:0]       cfg_data_i,
  input  logic signed [wrdb_pkg::SampleBits-1:0] sample_i,
  input  wrdb_pkg::cmd_t                     cmd_i,
  output wrdb_pkg::sts_t                     sts_o,
  output logic signed [15:0]                 level_db_o,
  output logic                               log_domain_error_o
);
  import wrdb_pkg::*;

  logic [WinBits-1:0]        win_q;
  logic [CfgBits-1:0]        gain_q;
  logic signed [CfgBits-1:0] pgain_q;
  logic [CfgBits-1:0]        offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q    <= 17'd1024;
      gain_q   <= 24'd65536;
      pgain_q  <= 24'sd65536;
      offset_q <= 24'd1;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        RegWindow:   win_q    <= cfg_data_i[WinBits-1:0];
        RegGain:     gain_q   <= cfg_data_i;
        RegPostGain: pgain_q  <= cfg_data_i;
        RegOffset:   offset_q <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  // Accumulation of squared samples.
  logic [EnergyBits-1:0]   e_q, e_next;
  logic [WinBits-1:0]      cnt_q, n_w, win_w;
  logic signed [31:0]      sq_full;
  logic [EnergyBits:0]     e_sum;

  assign sq_full = sample_i * sample_i;
  assign e_sum   = {1'b0, e_q} + (EnergyBits+1)'(sq_full[30:0]);
  assign e_next  = (e_sum > {1'b0, EnergyMax}) ? EnergyMax : e_sum[EnergyBits-1:0];
  assign n_w     = cnt_q + 1'b1;

  always_comb begin
    win_w = win_q;
    if (win_q == '0) win_w = 17'd1;
    else if (win_q > WinMax) win_w = WinMax;
  end

  assign sts_o.fire = (n_w >= win_w);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_q   <= '0;
      cnt_q <= '0;
    end else if (cmd_i.acc) begin
      if (sts_o.fire) begin
        e_q   <= '0;
        cnt_q <= '0;
      end else begin
        e_q   <= e_next;
        cnt_q <= n_w;
      end
    end
  end

  // Restoring division of energy * 2^48 by full scale times count.
  logic [DividendLen-1:0] dvd_q;
  logic [WinBits-1:0]     n_q;
  logic [DivBits-1:0]     d_q;
  logic [DivBits:0]       rem_q, rem_new;
  logic [DivBits+1:0]     rem_w;
  logic [QuotBits-1:0]    q_q;
  logic                   sat_q, qb;
  logic [63:0]            q_w;

  assign rem_w   = {rem_q, dvd_q[DividendLen-1]};
  assign qb      = (rem_w >= {2'b0, d_q});
  assign rem_new = qb ? (DivBits+1)'(rem_w - {2'b0, d_q}) : rem_w[DivBits:0];
  assign q_w     = {q_q, qb};

  // Integer square root, two bits per step.
  logic [63:0] v_q, r_q, bit_q, rb_w;
  assign rb_w = r_q + bit_q;

  // Log argument, normalization and log2 by repeated squaring.
  logic [XBits-1:0]   x_q;
  logic [5:0]         p_q;
  logic [30:0]        m_q;
  logic [61:0]        msq;
  logic [23:0]        frac_q;
  logic signed [7:0]  pm40;
  logic signed [31:0] l_w;
  logic signed [62:0] gprod;
  logic signed [31:0] g_q;
  logic signed [36:0] g20;
  logic signed [60:0] t_q;
  logic signed [28:0] lvl_w;
  logic               err_q;
  logic signed [15:0] sat_lvl;

  assign msq  = m_q * m_q;
  assign pm40 = $signed({2'b0, p_q}) - 8'sd40;
  assign l_w  = {pm40, frac_q};
  assign gprod = l_w * $signed({1'b0, Log10Two});
  assign g20  = (37'(g_q) <<< 4) + (37'(g_q) <<< 2);
  assign lvl_w = t_q[60:32];

  always_comb begin
    if (lvl_w > 29'sd32767)       sat_lvl = 16'sh7FFF;
    else if (lvl_w < -29'sd32768) sat_lvl = -16'sh8000;
    else                          sat_lvl = lvl_w[15:0];
  end

  assign sts_o.x_zero = (x_q == '0);
  assign sts_o.x_norm = x_q[XBits-1];

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc && sts_o.fire) begin
      dvd_q <= {e_next, 48'b0};
      n_q   <= n_w;
    end
    if (cmd_i.prep) begin
      d_q   <= DivBits'(n_q) * DivBits'(FullScale);
      rem_q <= '0;
      q_q   <= '0;
      sat_q <= 1'b0;
    end
    if (cmd_i.div) begin
      dvd_q <= dvd_q << 1;
      rem_q <= rem_new;
      if (!sat_q) begin
        if (q_w >= QSat) begin
          q_q   <= QSat[QuotBits-1:0];
          sat_q <= 1'b1;
        end else begin
          q_q <= q_w[QuotBits-1:0];
        end
      end
    end
    if (cmd_i.sqi) begin
      v_q   <= {1'b0, q_q};
      r_q   <= '0;
      bit_q <= QSat;
    end
    if (cmd_i.sqrt) begin
      if (v_q >= rb_w) begin
        v_q <= v_q - rb_w;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (cmd_i.mulx) begin
      x_q <= XBits'(gain_q) * XBits'(r_q[31:0]) + XBits'({offset_q, 16'b0});
      p_q <= 6'(XBits - 1);
    end
    if (cmd_i.norm) begin
      x_q <= x_q << 1;
      p_q <= p_q - 1'b1;
    end
    if (cmd_i.err) err_q <= 1'b1;
    if (cmd_i.logi) begin
      m_q    <= x_q[XBits-1:XBits-31];
      frac_q <= '0;
      err_q  <= 1'b0;
    end
    if (cmd_i.logs) begin
      if (msq[61]) begin
        m_q    <= msq[61:31];
        frac_q <= {frac_q[22:0], 1'b1};
      end else begin
        m_q    <= msq[60:30];
        frac_q <= {frac_q[22:0], 1'b0};
      end
    end
    if (cmd_i.gmul) g_q <= gprod[61:30];
    if (cmd_i.tmul) t_q <= g20 * pgain_q;
    if (cmd_i.load) begin
      level_db_o         <= err_q ? -16'sh8000 : sat_lvl;
      log_domain_error_o <= err_q;
    end
  end

endmodule
